// File: sv/ccps_pkg.sv
// shared types, codes and the tag decode for the constant pool scanner
// no dependencies; used by every module of the block
package ccps_pkg;

    // parse phase of the scanner
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COUNT_LO,
        PH_TAG,
        PH_BODY
    } phase_t;

    // result status codes
    localparam logic [1:0] ST_ENTRY   = 2'd0;
    localparam logic [1:0] ST_BAD_TAG = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // reference kind codes
    localparam logic [1:0] REF_NONE  = 2'd0;
    localparam logic [1:0] REF_CLASS = 2'd1;
    localparam logic [1:0] REF_DESC  = 2'd2;

    // constant pool tags with special handling
    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;

    // fixed file offsets around the pool count
    localparam logic [31:0] COUNT_LO_OFFSET  = 32'd9;
    localparam logic [31:0] EMPTY_END_OFFSET = 32'd10;

    // one accepted input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } item_t;

    // one entry report
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entry_index;
        logic [7:0]  tag;
        logic [31:0] content_offset;
        logic [31:0] end_offset;
        logic [15:0] utf8_length;
        logic [1:0]  ref_kind;
        logic [15:0] ref_index;
        logic        last;
    } result_t;

    // body byte count for a tag, zero for an unknown tag (utf8 gives its length field)
    function automatic logic [3:0] body_size(input logic [7:0] t);
        logic [3:0] sz;
        unique case (t)
            8'd1:                    sz = 4'd2;
            8'd3, 8'd4:              sz = 4'd4;
            8'd5, 8'd6:              sz = 4'd8;
            8'd7, 8'd8:              sz = 4'd2;
            8'd9, 8'd10, 8'd11, 8'd12: sz = 4'd4;
            8'd15:                   sz = 4'd3;
            8'd16:                   sz = 4'd2;
            8'd17, 8'd18:            sz = 4'd4;
            8'd19, 8'd20:            sz = 4'd2;
            default:                 sz = 4'd0;
        endcase
        return sz;
    endfunction

endpackage

// File: sv/ccps_byte_if.sv
// valid/ready channel carrying class file bytes into the scanner
// no package dependency
interface ccps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// File: sv/ccps_entry_if.sv
// valid/ready channel carrying constant pool entry reports out of the scanner
// no package dependency
interface ccps_entry_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] entry_index;
    logic [7:0]  tag;
    logic [31:0] content_offset;
    logic [31:0] end_offset;
    logic [15:0] utf8_length;
    logic [1:0]  ref_kind;
    logic [15:0] ref_index;
    logic        last;

    modport source (
        output valid, output status, output entry_index, output tag,
        output content_offset, output end_offset, output utf8_length,
        output ref_kind, output ref_index, output last, input ready
    );
    modport sink (
        input valid, input status, input entry_index, input tag,
        input content_offset, input end_offset, input utf8_length,
        input ref_kind, input ref_index, input last, output ready
    );
endinterface

// File: sv/ccps_input_stage.sv
// input register for the byte channel, one byte deep
// depends on ccps_pkg and ccps_byte_if
module ccps_input_stage (
    input  logic             clk,
    input  logic             rst_n,
    ccps_byte_if.sink        byte_ch,
    input  logic             take,
    output logic             item_valid,
    output ccps_pkg::item_t  item
);

    logic            valid_reg;
    ccps_pkg::item_t item_reg;

    // register can load when empty or when its byte leaves this cycle
    assign byte_ch.ready = !valid_reg || take;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            valid_reg <= byte_ch.valid;
        end
    end

    // payload capture on transfer
    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            item_reg.data_byte <= byte_ch.data_byte;
            item_reg.start_req <= byte_ch.start_req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/ccps_parse_core.sv
// parse state, per-byte next-state logic and the result register
// depends on ccps_pkg
module ccps_parse_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  ccps_pkg::item_t    item,
    output logic               take,
    input  logic               res_ready,
    output logic               res_valid,
    output ccps_pkg::result_t  res
);

    // parse state
    ccps_pkg::phase_t phase_reg, phase_next;
    logic [31:0] byte_offset_reg, byte_offset_next;
    logic [15:0] pool_count_reg, pool_count_next;
    logic [15:0] slot_index_reg, slot_index_next;
    logic [7:0]  current_tag_reg, current_tag_next;
    logic [16:0] bytes_left_reg, bytes_left_next;
    logic [16:0] body_position_reg, body_position_next;
    logic [15:0] captured_length_reg, captured_length_next;
    logic [15:0] captured_ref_reg, captured_ref_next;
    logic [31:0] entry_start_reg, entry_start_next;

    // result register
    logic              res_valid_reg;
    ccps_pkg::result_t res_reg, res_next;
    logic              emit;

    // working values
    logic [7:0]  b;
    logic [31:0] off_inc;
    logic [15:0] count_full;
    logic [3:0]  tag_size;
    logic [16:0] next_slot;
    logic        is_last;
    logic [1:0]  kind;

    assign take = item_valid && (!res_valid_reg || res_ready);
    assign b    = item.data_byte;

    // next state and result for the byte in the input register
    always_comb
    begin
        phase_next           = phase_reg;
        byte_offset_next     = byte_offset_reg;
        pool_count_next      = pool_count_reg;
        slot_index_next      = slot_index_reg;
        current_tag_next     = current_tag_reg;
        bytes_left_next      = bytes_left_reg;
        body_position_next   = body_position_reg;
        captured_length_next = captured_length_reg;
        captured_ref_next    = captured_ref_reg;
        entry_start_next     = entry_start_reg;
        emit                 = 1'b0;
        res_next             = '0;
        off_inc              = byte_offset_reg + 32'd1;
        count_full           = {pool_count_reg[15:8], b};
        tag_size             = ccps_pkg::body_size(b);
        next_slot            = '0;
        is_last              = 1'b0;
        kind                 = ccps_pkg::REF_NONE;

        if (item.start_req)
        begin
            pool_count_next  = {b, 8'h00};
            byte_offset_next = ccps_pkg::COUNT_LO_OFFSET;
            phase_next       = ccps_pkg::PH_COUNT_LO;
        end
        else
        begin
            byte_offset_next = off_inc;
            unique case (phase_reg)
                ccps_pkg::PH_IDLE:
                begin
                end
                ccps_pkg::PH_COUNT_LO:
                begin
                    pool_count_next = count_full;
                    if (count_full <= 16'd1)
                    begin
                        // pool holds no entries
                        phase_next          = ccps_pkg::PH_IDLE;
                        emit                = 1'b1;
                        res_next.status     = ccps_pkg::ST_EMPTY;
                        res_next.end_offset = ccps_pkg::EMPTY_END_OFFSET;
                        res_next.last       = 1'b1;
                    end
                    else
                    begin
                        slot_index_next = 16'd1;
                        phase_next      = ccps_pkg::PH_TAG;
                    end
                end
                ccps_pkg::PH_TAG:
                begin
                    current_tag_next = b;
                    entry_start_next = byte_offset_reg;
                    if (tag_size == 4'd0)
                    begin
                        // unknown tag halts the parse
                        phase_next              = ccps_pkg::PH_IDLE;
                        emit                    = 1'b1;
                        res_next.status         = ccps_pkg::ST_BAD_TAG;
                        res_next.entry_index    = slot_index_reg;
                        res_next.tag            = b;
                        res_next.content_offset = off_inc;
                        res_next.end_offset     = off_inc;
                        res_next.last           = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next      = {13'd0, tag_size};
                        body_position_next   = '0;
                        captured_length_next = '0;
                        captured_ref_next    = '0;
                        phase_next           = ccps_pkg::PH_BODY;
                    end
                end
                ccps_pkg::PH_BODY:
                begin
                    // capture index and length fields
                    if (current_tag_reg == ccps_pkg::TAG_CLASS ||
                        current_tag_reg == ccps_pkg::TAG_METHOD_TYPE)
                    begin
                        if (body_position_reg == 17'd0)
                            captured_ref_next = {b, 8'h00};
                        else if (body_position_reg == 17'd1)
                            captured_ref_next = {captured_ref_reg[15:8], b};
                    end
                    else if (current_tag_reg == ccps_pkg::TAG_NAME_AND_TYPE)
                    begin
                        if (body_position_reg == 17'd2)
                            captured_ref_next = {b, 8'h00};
                        else if (body_position_reg == 17'd3)
                            captured_ref_next = {captured_ref_reg[15:8], b};
                    end
                    else if (current_tag_reg == ccps_pkg::TAG_UTF8)
                    begin
                        if (body_position_reg == 17'd0)
                            captured_length_next = {b, 8'h00};
                        else if (body_position_reg == 17'd1)
                            captured_length_next = {captured_length_reg[15:8], b};
                    end

                    body_position_next = body_position_reg + 17'd1;
                    bytes_left_next    = bytes_left_reg - 17'd1;
                    // utf8 string bytes follow the length field
                    if (current_tag_reg == ccps_pkg::TAG_UTF8 && body_position_reg == 17'd1)
                        bytes_left_next = {1'b0, captured_length_next};

                    if (current_tag_reg == ccps_pkg::TAG_CLASS)
                        kind = ccps_pkg::REF_CLASS;
                    else if (current_tag_reg == ccps_pkg::TAG_NAME_AND_TYPE ||
                             current_tag_reg == ccps_pkg::TAG_METHOD_TYPE)
                        kind = ccps_pkg::REF_DESC;

                    // long and double take two slots
                    if (current_tag_reg == ccps_pkg::TAG_LONG ||
                        current_tag_reg == ccps_pkg::TAG_DOUBLE)
                        next_slot = {1'b0, slot_index_reg} + 17'd2;
                    else
                        next_slot = {1'b0, slot_index_reg} + 17'd1;
                    is_last = next_slot >= {1'b0, pool_count_reg};

                    if (bytes_left_next == 17'd0)
                    begin
                        emit                    = 1'b1;
                        res_next.status         = ccps_pkg::ST_ENTRY;
                        res_next.entry_index    = slot_index_reg;
                        res_next.tag            = current_tag_reg;
                        res_next.content_offset = entry_start_reg + 32'd1;
                        res_next.end_offset     = off_inc;
                        res_next.utf8_length    =
                            (current_tag_reg == ccps_pkg::TAG_UTF8) ? captured_length_next : 16'd0;
                        res_next.ref_kind       = kind;
                        res_next.ref_index      =
                            (kind != ccps_pkg::REF_NONE) ? captured_ref_next : 16'd0;
                        res_next.last           = is_last;
                        slot_index_next         = next_slot[15:0];
                        phase_next = is_last ? ccps_pkg::PH_IDLE : ccps_pkg::PH_TAG;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= ccps_pkg::PH_IDLE;
            byte_offset_reg     <= '0;
            pool_count_reg      <= '0;
            slot_index_reg      <= '0;
            current_tag_reg     <= '0;
            bytes_left_reg      <= '0;
            body_position_reg   <= '0;
            captured_length_reg <= '0;
            captured_ref_reg    <= '0;
            entry_start_reg     <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg           <= phase_next;
                byte_offset_reg     <= byte_offset_next;
                pool_count_reg      <= pool_count_next;
                slot_index_reg      <= slot_index_next;
                current_tag_reg     <= current_tag_next;
                bytes_left_reg      <= bytes_left_next;
                body_position_reg   <= body_position_next;
                captured_length_reg <= captured_length_next;
                captured_ref_reg    <= captured_ref_next;
                entry_start_reg     <= entry_start_next;
                res_valid_reg       <= emit;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: sv/class_constant_pool_scanner.sv
// Constant pool scanner for a class file byte stream.
// Channels: byte_ch takes one class file byte per transfer, starting with the
// byte at file offset 8 marked by start_req; entry_ch gives one report per
// constant pool entry, one empty-pool report, or one unknown-tag report.
// A byte goes into a one-deep input register; when the byte moves on, the parse
// logic updates the state and loads the result register. An entry's report raises
// entry_ch.valid once the entry's last byte moves on from the input register, and
// is held there until entry_ch.ready takes it.
// Throughput is one byte per cycle: the input register takes a new byte in
// the same cycle the held byte moves on, and the held byte moves on whenever
// the result register is empty or being read.
// While entry_ch stalls with a report held, no byte moves into the parser, so
// byte_ch stops as soon as the input register holds a byte.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to idle; bytes without start_req are then ignored until a start.
// After an unknown tag or the last entry the parser also idles until the
// next start_req.
// depends on ccps_pkg, ccps_byte_if, ccps_entry_if, ccps_input_stage,
// ccps_parse_core
module class_constant_pool_scanner (
    input  logic          clk,
    input  logic          rst_n,
    ccps_byte_if.sink     byte_ch,
    ccps_entry_if.source  entry_ch
);

    logic              item_valid;
    ccps_pkg::item_t   item;
    logic              take;
    logic              res_valid;
    ccps_pkg::result_t res;

    // input register
    ccps_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // parser and result register
    ccps_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_ready  (entry_ch.ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result channel
    assign entry_ch.valid          = res_valid;
    assign entry_ch.status         = res.status;
    assign entry_ch.entry_index    = res.entry_index;
    assign entry_ch.tag            = res.tag;
    assign entry_ch.content_offset = res.content_offset;
    assign entry_ch.end_offset     = res.end_offset;
    assign entry_ch.utf8_length    = res.utf8_length;
    assign entry_ch.ref_kind       = res.ref_kind;
    assign entry_ch.ref_index      = res.ref_index;
    assign entry_ch.last           = res.last;

    // byte channel stalls only with a byte held in the input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ch.ready |-> item_valid)
        else $error("byte channel stalled with empty input register");

    // empty pool report is final and ends at offset 10
    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_ch.valid && entry_ch.status == ccps_pkg::ST_EMPTY) |->
            (entry_ch.last && entry_ch.end_offset == ccps_pkg::EMPTY_END_OFFSET))
        else $error("malformed empty pool report");

    // unknown tag report is final and has no body
    a_bad_tag_report: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_ch.valid && entry_ch.status == ccps_pkg::ST_BAD_TAG) |->
            (entry_ch.last && entry_ch.end_offset == entry_ch.content_offset &&
             entry_ch.ref_kind == ccps_pkg::REF_NONE))
        else $error("malformed unknown tag report");

    // a new report appears only after a byte moved into the parser
    a_report_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(entry_ch.valid) |-> $past(take))
        else $error("report appeared without a parsed byte");

endmodule

// File: verif/tb_class_constant_pool_scanner.sv
`timescale 1ns / 100ps
// testbench for class_constant_pool_scanner: random class file pools in, entry reports checked
// depends on ccps_pkg, ccps_byte_if, ccps_entry_if and the scanner rtl

// tags that the package does not name
localparam logic [7:0] TAG_INTEGER        = 8'd3;
localparam logic [7:0] TAG_FLOAT          = 8'd4;
localparam logic [7:0] TAG_STRING         = 8'd8;
localparam logic [7:0] TAG_FIELDREF       = 8'd9;
localparam logic [7:0] TAG_METHODREF      = 8'd10;
localparam logic [7:0] TAG_IFACE_METHOD   = 8'd11;
localparam logic [7:0] TAG_METHOD_HANDLE  = 8'd15;
localparam logic [7:0] TAG_DYNAMIC        = 8'd17;
localparam logic [7:0] TAG_INVOKE_DYNAMIC = 8'd18;
localparam logic [7:0] TAG_MODULE         = 8'd19;
localparam logic [7:0] TAG_PACKAGE        = 8'd20;

// bytes that follow a tag, utf8 counts only its length field, 0 for unknown tags
function automatic int unsigned tag_body_len(input logic [7:0] t);
    case (t)
        ccps_pkg::TAG_UTF8, ccps_pkg::TAG_CLASS, TAG_STRING, ccps_pkg::TAG_METHOD_TYPE,
        TAG_MODULE, TAG_PACKAGE:
            return 2;
        TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_METHOD,
        ccps_pkg::TAG_NAME_AND_TYPE, TAG_DYNAMIC, TAG_INVOKE_DYNAMIC:
            return 4;
        ccps_pkg::TAG_LONG, ccps_pkg::TAG_DOUBLE:
            return 8;
        TAG_METHOD_HANDLE:
            return 3;
        default:
            return 0;
    endcase
endfunction

// tracks the pool walk and holds the entry reports still owed by the scanner
class entry_report_board;
    ccps_pkg::result_t pending[$];
    int unsigned       mismatches;

    logic [31:0]       next_offset;
    ccps_pkg::phase_t  walk_phase;
    logic [15:0]       pool_size;
    logic [15:0]       slot;
    logic [7:0]        cur_tag;
    logic [16:0]       remaining;
    logic [16:0]       body_pos;
    logic [15:0]       str_len;
    logic [15:0]       ref_idx;
    logic [31:0]       tag_offset;

    function new();
        mismatches  = 0;
        next_offset = '0;
        walk_phase  = ccps_pkg::PH_IDLE;
        pool_size   = '0;
        slot        = '0;
        cur_tag     = '0;
        remaining   = '0;
        body_pos    = '0;
        str_len     = '0;
        ref_idx     = '0;
        tag_offset  = '0;
    endfunction

    // advance the walk by one transferred byte, queue a report if one is due
    function void take_byte(input logic [7:0] b, input logic s);
        ccps_pkg::result_t rep;
        logic [31:0]       here;
        logic [16:0]       next_slot;
        logic [1:0]        kind;
        rep = '0;
        // a start always wins and loads the count high byte
        if (s)
        begin
            pool_size   = {b, 8'h00};
            next_offset = ccps_pkg::COUNT_LO_OFFSET;
            walk_phase  = ccps_pkg::PH_COUNT_LO;
            return;
        end
        here        = next_offset;
        next_offset = here + 32'd1;
        case (walk_phase)
            ccps_pkg::PH_COUNT_LO:
            begin
                pool_size[7:0] = b;
                if (pool_size <= 16'd1)
                begin
                    walk_phase     = ccps_pkg::PH_IDLE;
                    rep.status     = ccps_pkg::ST_EMPTY;
                    rep.end_offset = ccps_pkg::EMPTY_END_OFFSET;
                    rep.last       = 1'b1;
                    pending.push_back(rep);
                end
                else
                begin
                    slot       = 16'd1;
                    walk_phase = ccps_pkg::PH_TAG;
                end
            end
            ccps_pkg::PH_TAG:
            begin
                cur_tag    = b;
                tag_offset = here;
                if (tag_body_len(b) == 0)
                begin
                    walk_phase         = ccps_pkg::PH_IDLE;
                    rep.status         = ccps_pkg::ST_BAD_TAG;
                    rep.entry_index    = slot;
                    rep.tag            = b;
                    rep.content_offset = here + 32'd1;
                    rep.end_offset     = here + 32'd1;
                    rep.last           = 1'b1;
                    pending.push_back(rep);
                end
                else
                begin
                    remaining  = 17'(tag_body_len(b));
                    body_pos   = '0;
                    str_len    = '0;
                    ref_idx    = '0;
                    walk_phase = ccps_pkg::PH_BODY;
                end
            end
            ccps_pkg::PH_BODY:
            begin
                // pick up the length or the index from its body position
                if (cur_tag == ccps_pkg::TAG_CLASS || cur_tag == ccps_pkg::TAG_METHOD_TYPE)
                begin
                    if (body_pos == 17'd0)
                        ref_idx = {b, 8'h00};
                    else if (body_pos == 17'd1)
                        ref_idx[7:0] = b;
                end
                else if (cur_tag == ccps_pkg::TAG_NAME_AND_TYPE)
                begin
                    if (body_pos == 17'd2)
                        ref_idx = {b, 8'h00};
                    else if (body_pos == 17'd3)
                        ref_idx[7:0] = b;
                end
                else if (cur_tag == ccps_pkg::TAG_UTF8)
                begin
                    if (body_pos == 17'd0)
                        str_len = {b, 8'h00};
                    else if (body_pos == 17'd1)
                        str_len[7:0] = b;
                end
                remaining = remaining - 17'd1;
                if (cur_tag == ccps_pkg::TAG_UTF8 && body_pos == 17'd1)
                    remaining = {1'b0, str_len};
                body_pos = body_pos + 17'd1;
                // entry complete
                if (remaining == 17'd0)
                begin
                    kind = ccps_pkg::REF_NONE;
                    if (cur_tag == ccps_pkg::TAG_CLASS)
                        kind = ccps_pkg::REF_CLASS;
                    else if (cur_tag == ccps_pkg::TAG_NAME_AND_TYPE ||
                             cur_tag == ccps_pkg::TAG_METHOD_TYPE)
                        kind = ccps_pkg::REF_DESC;
                    next_slot = {1'b0, slot} +
                        ((cur_tag == ccps_pkg::TAG_LONG || cur_tag == ccps_pkg::TAG_DOUBLE) ?
                         17'd2 : 17'd1);
                    rep.status         = ccps_pkg::ST_ENTRY;
                    rep.entry_index    = slot;
                    rep.tag            = cur_tag;
                    rep.content_offset = tag_offset + 32'd1;
                    rep.end_offset     = here + 32'd1;
                    rep.utf8_length    = (cur_tag == ccps_pkg::TAG_UTF8) ? str_len : 16'd0;
                    rep.ref_kind       = kind;
                    rep.ref_index      = (kind != ccps_pkg::REF_NONE) ? ref_idx : 16'd0;
                    rep.last           = (next_slot >= {1'b0, pool_size});
                    pending.push_back(rep);
                    slot       = next_slot[15:0];
                    walk_phase = rep.last ? ccps_pkg::PH_IDLE : ccps_pkg::PH_TAG;
                end
            end
            default: ;
        endcase
    endfunction

    task flag(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task field_check(input string name, input logic [31:0] got, input logic [31:0] want,
                     input logic [15:0] idx);
        if (got !== want)
            flag($sformatf("entry %0d %s got 0x%0h expected 0x%0h", idx, name, got, want));
    endtask

    // compare one transferred report with the oldest one owed
    task match_report(input ccps_pkg::result_t got);
        ccps_pkg::result_t want;
        if (pending.size() == 0)
        begin
            flag($sformatf("report for entry %0d with none expected", got.entry_index));
            return;
        end
        want = pending.pop_front();
        field_check("status", 32'(got.status), 32'(want.status), want.entry_index);
        field_check("entry_index", 32'(got.entry_index), 32'(want.entry_index),
                    want.entry_index);
        field_check("tag", 32'(got.tag), 32'(want.tag), want.entry_index);
        field_check("content_offset", got.content_offset, want.content_offset,
                    want.entry_index);
        field_check("end_offset", got.end_offset, want.end_offset, want.entry_index);
        field_check("utf8_length", 32'(got.utf8_length), 32'(want.utf8_length),
                    want.entry_index);
        field_check("ref_kind", 32'(got.ref_kind), 32'(want.ref_kind), want.entry_index);
        field_check("ref_index", 32'(got.ref_index), 32'(want.ref_index), want.entry_index);
        field_check("last", 32'(got.last), 32'(want.last), want.entry_index);
    endtask
endclass

module tb_class_constant_pool_scanner;

    localparam int RANDOM_BYTES = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 12;

    logic clk;
    logic rst_n;

    ccps_byte_if  byte_ch();
    ccps_entry_if entry_ch();

    entry_report_board board;
    ccps_pkg::result_t seen_report;
    int                bytes_in;
    int                ignored_sent;
    int                stuck_cycles;
    bit                hold_done;

    class_constant_pool_scanner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .entry_ch (entry_ch)
    );

    assign seen_report = {entry_ch.status, entry_ch.entry_index, entry_ch.tag,
                          entry_ch.content_offset, entry_ch.end_offset,
                          entry_ch.utf8_length, entry_ch.ref_kind,
                          entry_ch.ref_index, entry_ch.last};

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // no idling on either side through the middle of the run
    function automatic bit in_quiet_stretch();
        return bytes_in >= 700 && bytes_in < 1000;
    endfunction

    // watch both channels: check reports, feed transferred bytes to the board
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (entry_ch.valid && entry_ch.ready)
                board.match_report(seen_report);
            if (byte_ch.valid && byte_ch.ready)
            begin
                board.take_byte(byte_ch.data_byte, byte_ch.start_req);
                bytes_in++;
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (entry_ch.valid && entry_ch.ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // report side ready: random stalls plus one long hold-off to back up the input
    always
    begin
        @(posedge clk);
        if (rst_n && !hold_done && bytes_in >= 400)
        begin
            hold_done = 1'b1;
            entry_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        else if (in_quiet_stretch())
            entry_ch.ready <= 1'b1;
        else
            entry_ch.ready <= ($urandom_range(99) >= 11);
    end

    // offer one byte, with random idle cycles ahead of it, until it transfers
    task automatic send_byte(input logic [7:0] b, input logic s);
        while (!in_quiet_stretch() && $urandom_range(99) < 11)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.start_req <= s;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_good_tag();
        logic [7:0] t;
        do
            t = 8'($urandom_range(1, 20));
        while (tag_body_len(t) == 0);
        return t;
    endfunction

    // unknown tags, the gaps below 21 picked often
    function automatic logic [7:0] random_bad_tag();
        logic [7:0] t;
        do
            t = $urandom_range(1) ? 8'($urandom_range(0, 22)) : 8'($urandom_range(255));
        while (tag_body_len(t) != 0);
        return t;
    endfunction

    // one whole entry with random content, utf8 strings mostly short
    task automatic send_entry(input logic [7:0] t);
        logic [15:0] len;
        send_byte(t, 1'b0);
        if (t == ccps_pkg::TAG_UTF8)
        begin
            len = ($urandom_range(9) == 0) ? 16'($urandom_range(6, 40))
                                           : 16'($urandom_range(0, 5));
            send_byte(len[15:8], 1'b0);
            send_byte(len[7:0], 1'b0);
            repeat (len) send_byte(8'($urandom_range(255)), 1'b0);
        end
        else
        begin
            repeat (tag_body_len(t)) send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // count bytes then entries up to the count; an unknown tag once bad_slot is reached
    task automatic send_pool(input logic [15:0] size, input int unsigned bad_slot);
        int unsigned at;
        logic [7:0]  t;
        at = 1;
        send_byte(size[15:8], 1'b1);
        send_byte(size[7:0], 1'b0);
        while (at < size)
        begin
            if (bad_slot != 0 && at >= bad_slot)
            begin
                send_byte(random_bad_tag(), 1'b0);
                return;
            end
            t = random_good_tag();
            send_entry(t);
            at += (t == ccps_pkg::TAG_LONG || t == ccps_pkg::TAG_DOUBLE) ? 2 : 1;
        end
    endtask

    // random count, a few entries, then a tag and up to three random bytes
    task automatic send_broken_pool();
        logic [15:0] size;
        size = 16'($urandom_range(65535));
        send_byte(size[15:8], 1'b1);
        send_byte(size[7:0], 1'b0);
        repeat ($urandom_range(0, 4)) send_entry(random_good_tag());
        send_byte(random_good_tag(), 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned size;
        rst_n              <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= 8'h00;
        byte_ch.start_req  <= 1'b0;
        entry_ch.ready     <= 1'b0;
        bytes_in     = 0;
        ignored_sent = 0;
        stuck_cycles = 0;
        hold_done    = 1'b0;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes before any start are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        ignored_sent += 2;
        // empty pools, count 0 and count 1
        send_pool(16'd0, 0);
        send_pool(16'd1, 0);
        // unknown tag in the first slot, then a byte while halted
        send_byte(8'h00, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        ignored_sent++;
        // empty utf8 string, then a long in the final slot
        send_byte(8'h00, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(ccps_pkg::TAG_UTF8, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ccps_pkg::TAG_LONG, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0);

        // random pools, mostly well formed
        while (bytes_in - ignored_sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                size = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
                send_pool(16'(size), 0);
            end
            else if (pick < 80)
                send_broken_pool();
            else if (pick < 86)
                send_pool(16'($urandom_range(1)), 0);
            else if (pick < 94)
            begin
                size = $urandom_range(2, 8);
                send_pool(16'(size), $urandom_range(1, size - 1));
            end
            else
            begin
                // stray bytes, dropped when the walk is idle
                size = $urandom_range(1, 3);
                repeat (size) send_byte(8'($urandom_range(255)), 1'b0);
                ignored_sent += size;
            end
        end
        byte_ch.valid <= 1'b0;

        // let the owed reports come out, then a few quiet cycles
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: class_constant_pool_scanner.f
sv/ccps_pkg.sv
sv/ccps_byte_if.sv
sv/ccps_entry_if.sv
sv/ccps_input_stage.sv
sv/ccps_parse_core.sv
sv/class_constant_pool_scanner.sv
verif/tb_class_constant_pool_scanner.sv
